@@ sv/ulh_pkg.sv @@
// ----------------------------------------------------------------------------
// ulh_pkg
// Shared constants, types and tables for the uniform LBP histogram block.
// ----------------------------------------------------------------------------
package ulh_pkg;

   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 4096;
   localparam int RING_ROWS     = 3;
   localparam int X_BITS        = $clog2(MAX_WIDTH);
   localparam int ROW_DEPTH     = RING_ROWS * MAX_WIDTH;
   localparam int ROW_ADDR_BITS = $clog2(ROW_DEPTH);
   localparam int COUNT_BITS    = 24;
   localparam int NUM_BINS      = 256;
   localparam int NUM_UNIFORM   = 58;
   localparam int WIDTH_BITS    = 12;
   localparam int HEIGHT_BITS   = 13;
   localparam int CSR_BITS      = 13;

   localparam logic CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic CSR_IMAGE_HEIGHT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CODE,
      ST_HWR,
      ST_MINMAX,
      ST_EMIT
   } state_type;

   // [row: top, middle, bottom][column: left, center, right]
   typedef logic [2:0][2:0][7:0] win_type;

   typedef struct packed {
      logic top_ok;
      logic bot_ok;
      logic left_ok;
      logic right_ok;
   } edge_type;

   function automatic logic [1:0] ring_inc(input logic [1:0] r);
      ring_inc = (r == 2'd2) ? 2'd0 : r + 2'd1;
   endfunction

   function automatic logic [1:0] ring_dec(input logic [1:0] r);
      ring_dec = (r == 2'd0) ? 2'd2 : r - 2'd1;
   endfunction

   function automatic logic [7:0] uniform_code(input logic [5:0] i);
      case (i)
         6'd0:  uniform_code = 8'd0;    6'd1:  uniform_code = 8'd1;
         6'd2:  uniform_code = 8'd2;    6'd3:  uniform_code = 8'd3;
         6'd4:  uniform_code = 8'd4;    6'd5:  uniform_code = 8'd6;
         6'd6:  uniform_code = 8'd7;    6'd7:  uniform_code = 8'd8;
         6'd8:  uniform_code = 8'd12;   6'd9:  uniform_code = 8'd14;
         6'd10: uniform_code = 8'd15;   6'd11: uniform_code = 8'd16;
         6'd12: uniform_code = 8'd24;   6'd13: uniform_code = 8'd28;
         6'd14: uniform_code = 8'd30;   6'd15: uniform_code = 8'd31;
         6'd16: uniform_code = 8'd32;   6'd17: uniform_code = 8'd48;
         6'd18: uniform_code = 8'd56;   6'd19: uniform_code = 8'd60;
         6'd20: uniform_code = 8'd62;   6'd21: uniform_code = 8'd63;
         6'd22: uniform_code = 8'd64;   6'd23: uniform_code = 8'd96;
         6'd24: uniform_code = 8'd112;  6'd25: uniform_code = 8'd120;
         6'd26: uniform_code = 8'd124;  6'd27: uniform_code = 8'd126;
         6'd28: uniform_code = 8'd127;  6'd29: uniform_code = 8'd128;
         6'd30: uniform_code = 8'd129;  6'd31: uniform_code = 8'd131;
         6'd32: uniform_code = 8'd135;  6'd33: uniform_code = 8'd143;
         6'd34: uniform_code = 8'd159;  6'd35: uniform_code = 8'd191;
         6'd36: uniform_code = 8'd192;  6'd37: uniform_code = 8'd193;
         6'd38: uniform_code = 8'd195;  6'd39: uniform_code = 8'd199;
         6'd40: uniform_code = 8'd207;  6'd41: uniform_code = 8'd223;
         6'd42: uniform_code = 8'd224;  6'd43: uniform_code = 8'd225;
         6'd44: uniform_code = 8'd227;  6'd45: uniform_code = 8'd231;
         6'd46: uniform_code = 8'd239;  6'd47: uniform_code = 8'd240;
         6'd48: uniform_code = 8'd241;  6'd49: uniform_code = 8'd243;
         6'd50: uniform_code = 8'd247;  6'd51: uniform_code = 8'd248;
         6'd52: uniform_code = 8'd249;  6'd53: uniform_code = 8'd251;
         6'd54: uniform_code = 8'd252;  6'd55: uniform_code = 8'd253;
         6'd56: uniform_code = 8'd254;  6'd57: uniform_code = 8'd255;
         default: uniform_code = 8'd0;
      endcase
   endfunction

endpackage

@@ sv/uniform_lbp_histogram.sv @@
// ----------------------------------------------------------------------------
// uniform_lbp_histogram
// Uniform 8-neighbor LBP histogram over a raster frame.
// ----------------------------------------------------------------------------
// A pixel transaction is taken when start is high and busy is low. Pixels
// arrive in raster order. Each accepted pixel is written into a three-row
// line store; a non-final pixel of a row leaves busy low. At each row end the
// block sweeps the row above through the line store (one RAM read port):
// per column it makes three reads, forms the code and does a histogram
// read-modify-write, with busy high until the sweep ends. On the final pixel
// the last two rows (one for a single-row frame) are swept, then the 256-bin
// histogram is scanned for its minimum and maximum, then 58 result
// transactions follow on back-to-back cycles, each marked by rsp_valid for
// one cycle, with rsp_last_bin on the last. The receiver cannot stall. The
// histogram is cleared on the last result cycle through per-bin valid flags.
// A csr write (only while idle) sets width or height and restarts the frame.
// Reset sets 640x480 and an empty histogram; no memory clearing pass is
// needed.
// ----------------------------------------------------------------------------
module uniform_lbp_histogram (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [7:0]                        req_pixel_value,
   input  logic                              csr_write_enable,
   input  logic                              csr_index,
   input  logic [ulh_pkg::CSR_BITS-1:0]      csr_write_data,
   output logic                              rsp_valid,
   output logic [5:0]                        rsp_bin_position,
   output logic [7:0]                        rsp_pattern_code,
   output logic [ulh_pkg::COUNT_BITS-1:0]    rsp_bin_count,
   output logic [ulh_pkg::COUNT_BITS-1:0]    rsp_hist_minimum,
   output logic [ulh_pkg::COUNT_BITS-1:0]    rsp_hist_maximum,
   output logic                              rsp_last_bin
);

   localparam int XB = ulh_pkg::X_BITS;
   localparam int WB = ulh_pkg::WIDTH_BITS;
   localparam int HB = ulh_pkg::HEIGHT_BITS;
   localparam int CB = ulh_pkg::COUNT_BITS;

   ulh_pkg::state_type state_ff, state_in;

   logic [WB-1:0]   width_ff, width_in;
   logic [HB-1:0]   height_ff, height_in;
   logic [XB-1:0]   col_x_ff, col_x_in;
   logic [HB-2:0]   row_y_ff, row_y_in;
   logic [1:0]      ry_ff, ry_in;
   logic [HB-2:0]   cy_ff, cy_in;
   logic [1:0]      cring_ff, cring_in;
   logic            fin_last_ff, fin_last_in;
   logic [WB-1:0]   nc_ff, nc_in;
   logic [1:0]      k_ff, k_in;
   logic [7:0]      t0_ff, t0_in, t1_ff, t1_in;
   ulh_pkg::win_type win_ff, win_in;
   logic [2:0]      wvalid_ff, wvalid_in;
   logic [7:0]      code_ff, code_in;
   logic [8:0]      mk_ff, mk_in;
   logic [5:0]      ek_ff, ek_in;
   logic [5:0]      epos_ff, epos_in;
   logic [7:0]      ecode_ff, ecode_in;
   logic [CB-1:0]   lo_ff, lo_in, hi_ff, hi_in;

   logic [ulh_pkg::NUM_BINS-1:0] hvalid_ff;
   logic            hvld_ff;
   logic            hclear, hset;

   logic [WB-1:0]   w_eff;
   logic [HB-1:0]   h_eff;
   logic            accept, row_end, frame_end;

   logic                           rs_we;
   logic [ulh_pkg::ROW_ADDR_BITS-1:0] rs_waddr, rs_raddr;
   logic [7:0]                     rs_rdata;
   logic [1:0]                     rd_ring;

   logic            h_we;
   logic [7:0]      h_raddr;
   logic [CB-1:0]   h_wdata, h_rdata, h_val;

   logic [7:0]      code_w;
   ulh_pkg::edge_type edges;

   assign w_eff = (width_ff == '0) ? WB'(1) :
                  (width_ff > WB'(ulh_pkg::MAX_WIDTH)) ? WB'(ulh_pkg::MAX_WIDTH) : width_ff;
   assign h_eff = (height_ff == '0) ? HB'(1) :
                  (height_ff > HB'(ulh_pkg::MAX_HEIGHT)) ? HB'(ulh_pkg::MAX_HEIGHT) : height_ff;

   assign busy      = (state_ff != ulh_pkg::ST_IDLE);
   assign accept    = start & ~busy;
   assign row_end   = ({1'b0, col_x_ff} + WB'(1)) == w_eff;
   assign frame_end = ({1'b0, row_y_ff} + HB'(1)) == h_eff;

   assign rs_we    = accept;
   assign rs_waddr = {ry_ff, col_x_ff};
   assign rd_ring  = (k_ff == 2'd0) ? ulh_pkg::ring_dec(cring_ff) :
                     (k_ff == 2'd1) ? cring_ff : ulh_pkg::ring_inc(cring_ff);
   assign rs_raddr = {rd_ring, nc_ff[XB-1:0]};

   ulh_ram #(.WIDTH(8), .DEPTH(ulh_pkg::ROW_DEPTH)) u_row_store (
      .clock   (clock),
      .wr_en   (rs_we),
      .wr_addr (rs_waddr),
      .wr_data (req_pixel_value),
      .rd_addr (rs_raddr),
      .rd_data (rs_rdata)
   );

   assign edges.top_ok   = (cy_ff != '0);
   assign edges.bot_ok   = ({1'b0, cy_ff} + HB'(1)) < h_eff;
   assign edges.left_ok  = wvalid_ff[0];
   assign edges.right_ok = wvalid_ff[2];

   ulh_code u_code (
      .win   (win_ff),
      .edges (edges),
      .code  (code_w)
   );

   assign h_val   = hvld_ff ? h_rdata : '0;
   assign h_we    = (state_ff == ulh_pkg::ST_HWR);
   assign h_wdata = (h_val == {CB{1'b1}}) ? h_val : h_val + CB'(1);
   assign hset    = h_we;

   always_comb begin
      case (state_ff)
         ulh_pkg::ST_MINMAX: h_raddr = mk_ff[7:0];
         ulh_pkg::ST_EMIT:   h_raddr = ulh_pkg::uniform_code(ek_ff);
         default:            h_raddr = code_w;
      endcase
   end

   ulh_ram #(.WIDTH(CB), .DEPTH(ulh_pkg::NUM_BINS)) u_hist (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (code_ff),
      .wr_data (h_wdata),
      .rd_addr (h_raddr),
      .rd_data (h_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset || hclear) begin
         hvalid_ff <= '0;
      end else if (hset) begin
         hvalid_ff[code_ff] <= 1'b1;
      end
      hvld_ff <= hvalid_ff[h_raddr];
   end

   // last row of the frame is the one that follows the first row swept
   // on the final pixel, unless the frame has a single row
   function automatic logic [HB-2:0] row_y_last(input logic [HB-2:0] cy);
      row_y_last = (h_eff == HB'(1)) ? cy : (HB-1)'(h_eff - HB'(1));
   endfunction

   always_comb begin
      state_in    = state_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      col_x_in    = col_x_ff;
      row_y_in    = row_y_ff;
      ry_in       = ry_ff;
      cy_in       = cy_ff;
      cring_in    = cring_ff;
      fin_last_in = fin_last_ff;
      nc_in       = nc_ff;
      k_in        = k_ff;
      t0_in       = t0_ff;
      t1_in       = t1_ff;
      win_in      = win_ff;
      wvalid_in   = wvalid_ff;
      code_in     = code_ff;
      mk_in       = mk_ff;
      ek_in       = ek_ff;
      epos_in     = epos_ff;
      ecode_in    = ecode_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      hclear      = 1'b0;
      rsp_valid   = 1'b0;

      case (state_ff)
         ulh_pkg::ST_IDLE: begin
            if (csr_write_enable) begin
               case (csr_index)
                  ulh_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_write_data[WB-1:0];
                  ulh_pkg::CSR_IMAGE_HEIGHT: height_in = csr_write_data;
                  default: ;
               endcase
               col_x_in = '0;
               row_y_in = '0;
               ry_in    = '0;
               hclear   = 1'b1;
            end else if (accept) begin
               col_x_in = col_x_ff + XB'(1);
               if (row_end) begin
                  col_x_in  = '0;
                  nc_in     = '0;
                  k_in      = '0;
                  wvalid_in = '0;
                  if (row_y_ff != '0) begin
                     cy_in    = row_y_ff - (HB-1)'(1);
                     cring_in = ulh_pkg::ring_dec(ry_ff);
                  end else begin
                     cy_in    = row_y_ff;
                     cring_in = ry_ff;
                  end
                  fin_last_in = frame_end;
                  if (frame_end) begin
                     row_y_in = '0;
                     ry_in    = '0;
                     state_in = ulh_pkg::ST_LOAD;
                  end else begin
                     row_y_in = row_y_ff + (HB-1)'(1);
                     ry_in    = ulh_pkg::ring_inc(ry_ff);
                     if (row_y_ff != '0) begin
                        state_in = ulh_pkg::ST_LOAD;
                     end
                  end
               end
            end
         end

         ulh_pkg::ST_LOAD: begin
            if (nc_ff >= w_eff) begin
               for (int r = 0; r < 3; r++) begin
                  win_in[r][0] = win_ff[r][1];
                  win_in[r][1] = win_ff[r][2];
                  win_in[r][2] = 8'd0;
               end
               wvalid_in = {1'b0, wvalid_ff[2:1]};
               nc_in     = nc_ff + WB'(1);
               state_in  = ulh_pkg::ST_CODE;
            end else begin
               k_in = k_ff + 2'd1;
               case (k_ff)
                  2'd1: t0_in = rs_rdata;
                  2'd2: t1_in = rs_rdata;
                  2'd3: begin
                     win_in[0] = {t0_ff, win_ff[0][2], win_ff[0][1]};
                     win_in[1] = {t1_ff, win_ff[1][2], win_ff[1][1]};
                     win_in[2] = {rs_rdata, win_ff[2][2], win_ff[2][1]};
                     wvalid_in = {1'b1, wvalid_ff[2:1]};
                     nc_in     = nc_ff + WB'(1);
                     state_in  = (nc_ff != '0) ? ulh_pkg::ST_CODE : ulh_pkg::ST_LOAD;
                  end
                  default: ;
               endcase
            end
         end

         ulh_pkg::ST_CODE: begin
            code_in  = code_w;
            state_in = ulh_pkg::ST_HWR;
         end

         ulh_pkg::ST_HWR: begin
            k_in = '0;
            if (nc_ff == w_eff + WB'(1)) begin
               if (fin_last_ff && (cy_ff != row_y_last(cy_ff))) begin
                  cy_in     = cy_ff + (HB-1)'(1);
                  cring_in  = ulh_pkg::ring_inc(cring_ff);
                  nc_in     = '0;
                  wvalid_in = '0;
                  state_in  = ulh_pkg::ST_LOAD;
               end else if (fin_last_ff) begin
                  mk_in    = '0;
                  state_in = ulh_pkg::ST_MINMAX;
               end else begin
                  state_in = ulh_pkg::ST_IDLE;
               end
            end else begin
               state_in = ulh_pkg::ST_LOAD;
            end
         end

         ulh_pkg::ST_MINMAX: begin
            mk_in = mk_ff + 9'd1;
            if (mk_ff == 9'd1) begin
               lo_in = h_val;
               hi_in = h_val;
            end else if (mk_ff != 9'd0) begin
               if (h_val < lo_ff) lo_in = h_val;
               if (h_val > hi_ff) hi_in = h_val;
            end
            if (mk_ff == 9'(ulh_pkg::NUM_BINS)) begin
               ek_in    = '0;
               state_in = ulh_pkg::ST_EMIT;
            end
         end

         ulh_pkg::ST_EMIT: begin
            ek_in     = ek_ff + 6'd1;
            epos_in   = ek_ff;
            ecode_in  = ulh_pkg::uniform_code(ek_ff);
            rsp_valid = (ek_ff != 6'd0);
            if (ek_ff == 6'(ulh_pkg::NUM_UNIFORM)) begin
               hclear   = 1'b1;
               state_in = ulh_pkg::ST_IDLE;
            end
         end

         default: state_in = ulh_pkg::ST_IDLE;
      endcase
   end

   assign rsp_bin_position = epos_ff;
   assign rsp_pattern_code = ecode_ff;
   assign rsp_bin_count    = h_val;
   assign rsp_hist_minimum = lo_ff;
   assign rsp_hist_maximum = hi_ff;
   assign rsp_last_bin     = (epos_ff == 6'(ulh_pkg::NUM_UNIFORM - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ulh_pkg::ST_IDLE;
         width_ff    <= WB'(640);
         height_ff   <= HB'(480);
         col_x_ff    <= '0;
         row_y_ff    <= '0;
         ry_ff       <= '0;
         fin_last_ff <= 1'b0;
         nc_ff       <= '0;
         k_ff        <= '0;
         wvalid_ff   <= '0;
         mk_ff       <= '0;
         ek_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         col_x_ff    <= col_x_in;
         row_y_ff    <= row_y_in;
         ry_ff       <= ry_in;
         fin_last_ff <= fin_last_in;
         nc_ff       <= nc_in;
         k_ff        <= k_in;
         wvalid_ff   <= wvalid_in;
         mk_ff       <= mk_in;
         ek_ff       <= ek_in;
      end
      cy_ff    <= cy_in;
      cring_ff <= cring_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      win_ff   <= win_in;
      code_ff  <= code_in;
      epos_ff  <= epos_in;
      ecode_ff <= ecode_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
   end

   a_rsp_only_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transaction while idle");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_bin |=> !rsp_valid && !busy)
      else $error("results continue after last bin");

   a_bins_in_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_bin |=>
         rsp_valid && (rsp_bin_position == $past(rsp_bin_position) + 6'd1))
      else $error("bin sequence broken");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hist_minimum <= rsp_hist_maximum) &&
                    (rsp_bin_count <= rsp_hist_maximum))
      else $error("histogram bounds inconsistent");

endmodule

@@ sv/ulh_ram.sv @@
// ----------------------------------------------------------------------------
// ulh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ulh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ulh_code.sv @@
// ----------------------------------------------------------------------------
// ulh_code
// Forms the 8-neighbor LBP code of the window center, clockwise from top-left.
// ----------------------------------------------------------------------------
module ulh_code (
   input  ulh_pkg::win_type  win,
   input  ulh_pkg::edge_type edges,
   output logic [7:0]        code
);

   logic [7:0] c;
   logic [7:0] ok;
   logic [7:0][7:0] nb;

   always_comb begin
      c     = win[1][1];
      nb[0] = win[0][0];  ok[0] = edges.top_ok & edges.left_ok;
      nb[1] = win[0][1];  ok[1] = edges.top_ok;
      nb[2] = win[0][2];  ok[2] = edges.top_ok & edges.right_ok;
      nb[3] = win[1][2];  ok[3] = edges.right_ok;
      nb[4] = win[2][2];  ok[4] = edges.bot_ok & edges.right_ok;
      nb[5] = win[2][1];  ok[5] = edges.bot_ok;
      nb[6] = win[2][0];  ok[6] = edges.bot_ok & edges.left_ok;
      nb[7] = win[1][0];  ok[7] = edges.left_ok;
      for (int i = 0; i < 8; i++) begin
         code[i] = ok[i] & (nb[i] >= c);
      end
   end

endmodule

@@ dv/tb_uniform_lbp_histogram.sv @@
// ----------------------------------------------------------------------------
// tb_uniform_lbp_histogram
// Self-checking bench for the uniform LBP histogram block: frames of pixels
// are streamed in with random gaps, a local predictor computes the 58 bins of
// each frame, and every result transaction is compared field by field.
// ----------------------------------------------------------------------------
module tb_uniform_lbp_histogram;

   typedef struct {
      logic [5:0]  pos;
      logic [7:0]  code;
      logic [23:0] count;
      logic [23:0] lo;
      logic [23:0] hi;
      logic        last;
   } bin_result_type;

   localparam int WATCHDOG_LIMIT = 2000;

   localparam int PAT_RANDOM      = 0;
   localparam int PAT_FLAT        = 1;
   localparam int PAT_BLACK_WHITE = 2;
   localparam int PAT_NARROW      = 3;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [7:0]  req_pixel_value;
   logic        csr_write_enable;
   logic        csr_index;
   logic [ulh_pkg::CSR_BITS-1:0] csr_write_data;
   logic        rsp_valid;
   logic [5:0]  rsp_bin_position;
   logic [7:0]  rsp_pattern_code;
   logic [ulh_pkg::COUNT_BITS-1:0] rsp_bin_count;
   logic [ulh_pkg::COUNT_BITS-1:0] rsp_hist_minimum;
   logic [ulh_pkg::COUNT_BITS-1:0] rsp_hist_maximum;
   logic        rsp_last_bin;

   uniform_lbp_histogram i_dut (.*);

   // predictor state
   logic [11:0] width_reg;
   logic [12:0] height_reg;
   logic [7:0]  line_ring [ulh_pkg::RING_ROWS*ulh_pkg::MAX_WIDTH];
   int unsigned bin_counts [ulh_pkg::NUM_BINS];
   int unsigned col_pos;
   int unsigned row_pos;
   logic [7:0]  uniform_list [ulh_pkg::NUM_UNIFORM];

   bin_result_type expected_bins [$];
   int   error_count;
   bit   gaps_on;
   int   quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > ulh_pkg::MAX_WIDTH) return ulh_pkg::MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > ulh_pkg::MAX_HEIGHT) return ulh_pkg::MAX_HEIGHT;
      return height_reg;
   endfunction

   function automatic void build_uniform_list();
      int n;
      int trans;
      logic [7:0] c;
      n = 0;
      for (int v = 0; v < 256; v++) begin
         c = 8'(v);
         trans = 0;
         for (int b = 0; b < 8; b++)
            if (c[b] != c[(b+1)%8]) trans++;
         if (trans <= 2) begin
            uniform_list[n] = c;
            n++;
         end
      end
   endfunction

   function automatic void clear_hist();
      foreach (bin_counts[i]) bin_counts[i] = 0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   function automatic void sweep_row(int cy, int w, int h);
      int dx [8] = '{-1, 0, 1, 1, 1, 0, -1, -1};
      int dy [8] = '{-1, -1, -1, 0, 1, 1, 1, 0};
      logic [7:0] ctr;
      logic [7:0] nb;
      logic [7:0] code;
      int nx;
      int ny;
      for (int x = 0; x < w; x++) begin
         ctr = line_ring[(cy % ulh_pkg::RING_ROWS)*ulh_pkg::MAX_WIDTH + x];
         code = '0;
         for (int i = 0; i < 8; i++) begin
            nx = x + dx[i];
            ny = cy + dy[i];
            if (nx >= 0 && ny >= 0 && nx < w && ny < h) begin
               nb = line_ring[(ny % ulh_pkg::RING_ROWS)*ulh_pkg::MAX_WIDTH + nx];
               code[i] = (nb >= ctr);
            end
         end
         if (bin_counts[code] < (1 << ulh_pkg::COUNT_BITS) - 1) bin_counts[code]++;
      end
   endfunction

   function automatic void predict_pixel(logic [7:0] v);
      int unsigned w;
      int unsigned h;
      int unsigned x;
      int unsigned y;
      int unsigned lo;
      int unsigned hi;
      bin_result_type r;
      w = eff_width();
      h = eff_height();
      x = col_pos;
      y = row_pos;
      if (x >= w || y >= h) begin
         x = 0;
         y = 0;
      end
      line_ring[(y % ulh_pkg::RING_ROWS)*ulh_pkg::MAX_WIDTH + x] = v;
      if (x + 1 < w) begin
         col_pos = x + 1;
         row_pos = y;
         return;
      end
      col_pos = 0;
      if (y >= 1) sweep_row(y - 1, w, h);
      if (y + 1 < h) begin
         row_pos = y + 1;
         return;
      end
      sweep_row(y, w, h);
      lo = bin_counts[0];
      hi = bin_counts[0];
      foreach (bin_counts[i]) begin
         if (bin_counts[i] < lo) lo = bin_counts[i];
         if (bin_counts[i] > hi) hi = bin_counts[i];
      end
      for (int i = 0; i < ulh_pkg::NUM_UNIFORM; i++) begin
         r.pos   = 6'(i);
         r.code  = uniform_list[i];
         r.count = 24'(bin_counts[uniform_list[i]]);
         r.lo    = 24'(lo);
         r.hi    = 24'(hi);
         r.last  = (i == ulh_pkg::NUM_UNIFORM - 1);
         expected_bins = {expected_bins, r};
      end
      clear_hist();
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      bin_result_type e;
      if (!reset && rsp_valid) begin
         if (expected_bins.size() == 0) begin
            report_mismatch("unexpected transaction, bin", rsp_bin_position, -1);
         end else begin
            e = expected_bins.pop_front();
            if (rsp_bin_position != e.pos) report_mismatch("bin_position", rsp_bin_position, e.pos);
            if (rsp_pattern_code != e.code) report_mismatch("pattern_code", rsp_pattern_code, e.code);
            if (rsp_bin_count != e.count) report_mismatch("bin_count", rsp_bin_count, e.count);
            if (rsp_hist_minimum != e.lo) report_mismatch("hist_minimum", rsp_hist_minimum, e.lo);
            if (rsp_hist_maximum != e.hi) report_mismatch("hist_maximum", rsp_hist_maximum, e.hi);
            if (rsp_last_bin != e.last) report_mismatch("last_bin", rsp_last_bin, e.last);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_pixel(logic [7:0] v);
      int n;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 9);
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_pixel_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_pixel(v);
   endtask

   task automatic write_csr(logic idx, logic [ulh_pkg::CSR_BITS-1:0] data);
      @(negedge clock);
      start <= 1'b0;
      while (expected_bins.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      while (busy) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      if (idx == ulh_pkg::CSR_IMAGE_WIDTH) width_reg = data[11:0];
      else height_reg = data;
      clear_hist();
   endtask

   task automatic set_size(logic [ulh_pkg::CSR_BITS-1:0] w,
                           logic [ulh_pkg::CSR_BITS-1:0] h);
      write_csr(ulh_pkg::CSR_IMAGE_WIDTH, w);
      write_csr(ulh_pkg::CSR_IMAGE_HEIGHT, h);
   endtask

   task automatic send_pixels(int n, int pattern);
      logic [7:0] v;
      logic [7:0] flat;
      flat = 8'($urandom);
      for (int i = 0; i < n; i++) begin
         case (pattern)
            PAT_FLAT:        v = flat;
            PAT_BLACK_WHITE: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PAT_NARROW:      v = 8'($urandom_range(0, 3));
            default:         v = 8'($urandom);
         endcase
         send_pixel(v);
      end
   endtask

   task automatic send_frame(int pattern);
      send_pixels(eff_width() * eff_height(), pattern);
   endtask

   task automatic test_reset_frame_abandon();
      send_pixels(5, PAT_RANDOM);
      set_size(3, 3);
      send_pixels(4, PAT_RANDOM);
      set_size(3, 3);
      send_frame(PAT_RANDOM);
   endtask

   task automatic test_directed_frames();
      set_size(1, 1);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      set_size(0, 0);
      send_pixel(8'h80);
      set_size(3, 3);
      send_frame(PAT_FLAT);
      send_frame(PAT_BLACK_WHITE);
      set_size(4, 2);
      send_frame(PAT_NARROW);
   endtask

   task automatic test_size_limits();
      set_size(4095, 1);
      send_pixels(6, PAT_NARROW);
      set_size(2048, 2);
      send_pixels(5, PAT_RANDOM);
      set_size(1, 8191);
      send_pixels(7, PAT_RANDOM);
      set_size(1, 4096);
      send_pixels(7, PAT_RANDOM);
   endtask

   task automatic test_random_frames();
      int sent;
      int n;
      sent = 0;
      while (sent < 30) begin
         set_size(13'($urandom_range(1, 6)), 13'($urandom_range(1, 6)));
         n = eff_width() * eff_height();
         if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
         send_pixels(n, $urandom_range(PAT_RANDOM, PAT_NARROW));
         sent += n;
      end
   endtask

   task automatic test_back_to_back();
      gaps_on = 1'b0;
      set_size(5, 4);
      send_frame(PAT_RANDOM);
      send_frame(PAT_NARROW);
      set_size(2, 7);
      send_frame(PAT_RANDOM);
   endtask

   initial begin
      build_uniform_list();
      error_count = 0;
      gaps_on = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_pixel_value = '0;
      csr_write_enable = 1'b0;
      csr_index = ulh_pkg::CSR_IMAGE_WIDTH;
      csr_write_data = '0;
      width_reg = 640;
      height_reg = 480;
      clear_hist();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_frame_abandon();
      test_directed_frames();
      test_size_limits();
      test_random_frames();
      test_back_to_back();

      @(negedge clock);
      start <= 1'b0;
      while (expected_bins.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/ulh_pkg.sv
sv/ulh_ram.sv
sv/ulh_code.sv
sv/uniform_lbp_histogram.sv
dv/tb_uniform_lbp_histogram.sv
